FILE: rtl/button_debounce_longpress_defines.svh
`ifndef BUTTON_DEBOUNCE_LONGPRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdl assertion failed");

// next-cycle implication
`define BDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdl assertion failed");

`endif

FILE: rtl/bdl_pkg.sv
`timescale 1ns / 1ps

package bdl_pkg;

   localparam logic [7:0]  DEBOUNCE_RESET  = 8'd200;
   localparam logic [15:0] LONGPRESS_RESET = 16'd6250;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_PIN  = 1'b1
   } bdl_op_type;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_DEBOUNCE  = 1'b0,
      REG_LONGPRESS = 1'b1
   } bdl_reg_type;

   typedef struct packed {
      logic op;
      logic reset_pressed;
      logic start_pressed;
      logic case_low;
   } bdl_req_type;

   typedef struct packed {
      logic reset_request;
      logic startstop_request;
      logic setmode_request;
      logic case_opened;
      logic case_closed;
   } bdl_rsp_type;

endpackage

FILE: rtl/bdl_if.sv
`timescale 1ns / 1ps

interface bdl_req_if;
   logic valid;
   logic ready;
   logic op;
   logic reset_pressed;
   logic start_pressed;
   logic case_low;

   modport source (output valid, op, reset_pressed, start_pressed, case_low, input ready);
   modport sink (input valid, op, reset_pressed, start_pressed, case_low, output ready);
endinterface

interface bdl_rsp_if;
   logic valid;
   logic ready;
   logic reset_request;
   logic startstop_request;
   logic setmode_request;
   logic case_opened;
   logic case_closed;

   modport source (output valid, reset_request, startstop_request, setmode_request,
                   case_opened, case_closed, input ready);
   modport sink (input valid, reset_request, startstop_request, setmode_request,
                 case_opened, case_closed, output ready);
endinterface

FILE: rtl/bdl_core.sv
`timescale 1ns / 1ps
`include "button_debounce_longpress_defines.svh"

module bdl_core
   import bdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  bdl_req_type item,
   input  logic [7:0]  debounce_ticks,
   input  logic [15:0] longpress_ticks,
   output bdl_rsp_type result
);

   logic [7:0]  reset_count_ff, reset_count_in;
   logic [7:0]  start_count_ff, start_count_in;
   logic [15:0] both_hold_ff, both_hold_in;
   logic [7:0]  open_count_ff, open_count_in;
   logic        marked_open_ff, marked_open_in;
   logic        pin_accept;
   logic        tick_accept;
   logic        both_load;
   logic        tick_event;
   logic        case_closing;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_count_ff <= '0;
         start_count_ff <= '0;
         both_hold_ff   <= '0;
         open_count_ff  <= '0;
         marked_open_ff <= 1'b1;
      end else if (accept) begin
         reset_count_ff <= reset_count_in;
         start_count_ff <= start_count_in;
         both_hold_ff   <= both_hold_in;
         open_count_ff  <= open_count_in;
         marked_open_ff <= marked_open_in;
      end
   end

   always_comb begin
      reset_count_in = reset_count_ff;
      start_count_in = start_count_ff;
      both_hold_in   = both_hold_ff;
      open_count_in  = open_count_ff;
      marked_open_in = marked_open_ff;
      result         = '0;
      if (item.op == OP_TICK) begin
         // a counter at one expires on this tick
         if (reset_count_ff != 8'd0) begin
            reset_count_in       = reset_count_ff - 8'd1;
            result.reset_request = (reset_count_ff == 8'd1) && !item.start_pressed;
         end
         if (start_count_ff != 8'd0) begin
            start_count_in           = start_count_ff - 8'd1;
            result.startstop_request = (start_count_ff == 8'd1) && !item.reset_pressed;
         end
         if (both_hold_ff != 16'd0) begin
            both_hold_in           = both_hold_ff - 16'd1;
            result.setmode_request = (both_hold_ff == 16'd1);
         end
         if (open_count_ff != 8'd0) begin
            open_count_in = open_count_ff - 8'd1;
            if ((open_count_ff == 8'd1) && item.case_low) begin
               marked_open_in     = 1'b1;
               result.case_opened = 1'b1;
            end
         end
      end else begin
         reset_count_in = item.reset_pressed ? debounce_ticks : 8'd0;
         start_count_in = item.start_pressed ? debounce_ticks : 8'd0;
         both_hold_in   = (item.reset_pressed && item.start_pressed) ? longpress_ticks : 16'd0;
         if (item.case_low) begin
            open_count_in = debounce_ticks;
         end else if (marked_open_ff) begin
            marked_open_in     = 1'b0;
            result.case_closed = 1'b1;
         end
      end
   end

   assign pin_accept   = accept && (item.op == OP_PIN);
   assign tick_accept  = accept && (item.op == OP_TICK);
   assign both_load    = pin_accept && item.reset_pressed && item.start_pressed;
   assign tick_event   = result.reset_request || result.startstop_request ||
                         result.setmode_request || result.case_opened;
   assign case_closing = accept && result.case_closed;

   `BDL_ASSERT_NOW(a_pin_only_closes, clock, reset, pin_accept, !tick_event)
   `BDL_ASSERT_NOW(a_tick_never_closes, clock, reset, tick_accept, !result.case_closed)
   `BDL_ASSERT_NEXT(a_closed_clears_mark, clock, reset, case_closing, !marked_open_ff)
   `BDL_ASSERT_NEXT(a_hold_load, clock, reset, both_load, both_hold_ff == $past(longpress_ticks))

endmodule

FILE: rtl/button_debounce_longpress.sv
// the result of an accepted item is registered and shows at the output register in the next cycle
// throughput: one item per cycle while the output register is not stalled; all counters update in a single pass
// an item is taken while the output register is empty or being drained
// reset (synchronous, active high) clears counters and the output valid,
// marks the case open and restores debounce 200 and long press 6250 ticks
`timescale 1ns / 1ps
`include "button_debounce_longpress_defines.svh"

module button_debounce_longpress
   import bdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bdl_req_if.sink     req,
   bdl_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]  debounce_ff;
   logic [15:0] longpress_ff;
   logic        csr_write;
   bdl_reg_type csr_reg;
   logic        deb_write;

   logic        req_accept;
   logic        rsp_accept;
   bdl_req_type item;
   bdl_rsp_type result;
   bdl_rsp_type rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = bdl_reg_type'(csr_paddr[2]);
   assign deb_write  = csr_write && (csr_reg == REG_DEBOUNCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         longpress_ff <= LONGPRESS_RESET;
      end else if (csr_write) begin
         case (csr_reg)
            REG_DEBOUNCE:  debounce_ff  <= csr_pwdata[7:0];
            REG_LONGPRESS: longpress_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_DEBOUNCE:  csr_prdata = {24'd0, debounce_ff};
         REG_LONGPRESS: csr_prdata = {16'd0, longpress_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;
   assign rsp_accept = rsp_valid_ff && rsp.ready;

   assign item.op            = req.op;
   assign item.reset_pressed = req.reset_pressed;
   assign item.start_pressed = req.start_pressed;
   assign item.case_low      = req.case_low;

   bdl_core u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .item            (item),
      .debounce_ticks  (debounce_ff),
      .longpress_ticks (longpress_ff),
      .result          (result)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.reset_request     = rsp_ff.reset_request;
   assign rsp.startstop_request = rsp_ff.startstop_request;
   assign rsp.setmode_request   = rsp_ff.setmode_request;
   assign rsp.case_opened       = rsp_ff.case_opened;
   assign rsp.case_closed       = rsp_ff.case_closed;

   `BDL_ASSERT_NOW(a_no_take_when_stalled, clock, reset, rsp_valid_ff && !rsp.ready, !req.ready)
   `BDL_ASSERT_NEXT(a_drain_empties, clock, reset, rsp_accept && !req_accept, !rsp_valid_ff)
   `BDL_ASSERT_NEXT(a_deb_write, clock, reset, deb_write, debounce_ff == $past(csr_pwdata[7:0]))

endmodule
